>>> sv/lexical_token_scanner_core_assert.svh
// ----------------------------------------------------------------------------
// lexical_token_scanner_core_assert
// Assertion macros shared by the scanner modules.
// ----------------------------------------------------------------------------
`ifndef LEXICAL_TOKEN_SCANNER_CORE_ASSERT_SVH
`define LEXICAL_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexical token scanner check failed");

// Next-cycle implication, checked outside reset.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexical token scanner check failed");

`endif

>>> sv/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Token codes, character constants, keyword tables and the result types
// shared by the lexical token scanner modules.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Token kinds.
  localparam logic [3:0] TK_IDENT   = 4'd0;
  localparam logic [3:0] TK_NUMBER  = 4'd1;
  localparam logic [3:0] TK_KEYWORD = 4'd2;
  localparam logic [3:0] TK_RELOP   = 4'd3;
  localparam logic [3:0] TK_ASSIGN  = 4'd4;
  localparam logic [3:0] TK_PUNCT   = 4'd5;
  localparam logic [3:0] TK_BAR     = 4'd6;
  localparam logic [3:0] TK_BARBAR  = 4'd7;
  localparam logic [3:0] TK_AMP     = 4'd8;
  localparam logic [3:0] TK_AMPAMP  = 4'd9;
  localparam logic [3:0] TK_SLASH   = 4'd10;
  localparam logic [3:0] TK_ERROR   = 4'd11;

  // Relational operator details.
  localparam logic [7:0] RO_LT = 8'd0;
  localparam logic [7:0] RO_LE = 8'd1;
  localparam logic [7:0] RO_NE = 8'd2;
  localparam logic [7:0] RO_GT = 8'd3;
  localparam logic [7:0] RO_GE = 8'd4;
  localparam logic [7:0] RO_EQ = 8'd5;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_BAR   = "|";
  localparam logic [7:0] CH_AMP   = "&";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_EXP   = "E";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_LBRC  = "{";
  localparam logic [7:0] CH_RBRC  = "}";
  localparam logic [7:0] CH_HASH  = "#";

  // Keywords, right aligned, with their lengths.
  localparam int KW_NUM     = 9;
  localparam int KW_MAX_LEN = 8;
  localparam logic [KW_NUM-1:0] KW_ALL = '1;
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'("int"), 64'("if"), 64'("while"), 64'("get"), 64'("put"),
    64'("return"), 64'("else"), 64'("include"), 64'("bool")
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd3, 4'd2, 4'd5, 4'd3, 4'd3, 4'd6, 4'd4, 4'd7, 4'd4
  };

  // Character p of keyword k, or zero past its end.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [63:0] w;
    logic [3:0]  l;
    logic [2:0]  sh;
    w  = KW_TEXT[k];
    l  = KW_LEN[k];
    sh = 3'(l - 4'd1 - {1'b0, p});
    if ({1'b0, p} >= l) begin
      return 8'd0;
    end
    return 8'(w >> {sh, 3'b000});
  endfunction

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  detail;
    logic [7:0]  length;
    logic [15:0] line;
    logic        last;
  } lts_res_t;

  // Results produced by one scanned byte.
  typedef struct packed {
    logic [1:0] n;
    lts_res_t   r0;
    lts_res_t   r1;
  } lts_push_t;

endpackage

>>> sv/lts_in_if.sv
// ----------------------------------------------------------------------------
// lts_in_if
// Source byte channel: one text byte and an end-of-input mark per transaction.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink   (input valid, char_byte, end_of_input, output ready);
endinterface

>>> sv/lts_out_if.sv
// ----------------------------------------------------------------------------
// lts_out_if
// Token channel: one token per transaction.
// ----------------------------------------------------------------------------
interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  token_detail;
  logic [7:0]  token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, token_kind, token_detail, token_length, line_number,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, token_detail, token_length, line_number,
                  last_of_run, output ready);
endinterface

>>> sv/lts_scan.sv
// ----------------------------------------------------------------------------
// lts_scan
// Scanner state machine: consumes one byte per step and produces up to two
// tokens, including the flush at end of input.
// ----------------------------------------------------------------------------
`include "lexical_token_scanner_core_assert.svh"

module lts_scan import lts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int LINE_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output lts_push_t  push
);

  localparam int CW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [4:0] {
    S_START, S_IDENT, S_INT, S_DOT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPDIG,
    S_LT, S_GT, S_EQ, S_BAR, S_AMP, S_SLASH, S_BLOCK, S_STAR, S_LINEC
  } scan_st_t;

  scan_st_t              state_r, st_nxt, sb_state;
  logic [CW-1:0]         cnt_r, cnt_nxt, cnt_inc;
  logic [KW_NUM-1:0]     mask_r, mask_nxt, sb_mask;
  logic [LINE_BITS-1:0]  line_r;

  logic       is_let, is_dig, is_ws, rescan;
  logic       a_emit, b_emit, b_take, f_emit;
  logic [3:0] a_kind, b_kind, f_kind;
  logic [7:0] a_det, f_det, a_len, f_len;
  logic [11:0] id_close, id_flush;
  lts_res_t   res_a, res_b, res_f;

  // Drop keywords whose character at pos differs from ch.
  function automatic logic [KW_NUM-1:0] kw_step(input logic [KW_NUM-1:0] m,
                                                input logic [CW-1:0] pos,
                                                input logic [7:0] ch);
    logic [KW_NUM-1:0] r;
    r = m;
    for (int k = 0; k < KW_NUM; k++) begin
      if (pos >= CW'(KW_MAX_LEN) || kw_char(4'(k), pos[2:0]) != ch) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Kind and detail of a finished identifier; the lowest matching keyword wins.
  function automatic logic [11:0] close_ident(input logic [KW_NUM-1:0] m,
                                              input logic [CW-1:0] n);
    logic [11:0] r;
    r = {TK_IDENT, 8'd0};
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (m[k] && n == CW'(KW_LEN[k])) begin
        r = {TK_KEYWORD, 8'(k)};
      end
    end
    return r;
  endfunction

  assign is_let  = (char_byte inside {["A":"Z"], ["a":"z"]});
  assign is_dig  = (char_byte inside {["0":"9"]});
  assign is_ws   = (char_byte inside {CH_SP, CH_TAB, CH_NL});
  assign cnt_inc = (cnt_r == CW'(MAX_TOKEN_LEN)) ? cnt_r : CW'(cnt_r + 1'b1);

  // Decode of a byte seen in the start state.
  always_comb begin
    sb_state = S_START;
    sb_mask  = KW_ALL;
    b_kind   = TK_ERROR;
    b_emit   = 1'b0;
    if (!is_ws) begin
      if (is_let) begin
        sb_state = S_IDENT;
        sb_mask  = kw_step(KW_ALL, '0, char_byte);
      end else if (is_dig) begin
        sb_state = S_INT;
      end else begin
        case (char_byte)
          CH_LT:    sb_state = S_LT;
          CH_GT:    sb_state = S_GT;
          CH_EQ:    sb_state = S_EQ;
          CH_BAR:   sb_state = S_BAR;
          CH_AMP:   sb_state = S_AMP;
          CH_SLASH: sb_state = S_SLASH;
          default: begin
            b_emit = 1'b1;
            if (char_byte inside {CH_PLUS, CH_MINUS, CH_BANG, CH_COMMA, CH_SEMI,
                                  CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC, CH_HASH}) begin
              b_kind = TK_PUNCT;
            end
          end
        endcase
      end
    end
  end

  assign id_close = close_ident(mask_r, cnt_r);

  // Transition on the current state; a byte that ends a token without
  // belonging to it is decoded again from the start state.
  always_comb begin
    st_nxt   = state_r;
    cnt_nxt  = cnt_r;
    mask_nxt = mask_r;
    a_emit   = 1'b0;
    a_kind   = TK_ERROR;
    a_det    = 8'd0;
    a_len    = 8'(cnt_r);
    rescan   = 1'b0;
    case (state_r)
      S_IDENT: begin
        if (is_let || is_dig) begin
          mask_nxt = kw_step(mask_r, cnt_r, char_byte);
          cnt_nxt  = cnt_inc;
        end else begin
          a_emit = 1'b1;
          {a_kind, a_det} = id_close;
          rescan = 1'b1;
        end
      end
      S_INT, S_FRAC: begin
        if (is_dig) begin
          cnt_nxt = cnt_inc;
        end else if (char_byte == CH_DOT && state_r == S_INT) begin
          cnt_nxt = cnt_inc;
          st_nxt  = S_DOT;
        end else if (char_byte == CH_EXP) begin
          cnt_nxt = cnt_inc;
          st_nxt  = S_EXP;
        end else begin
          a_emit = 1'b1;
          a_kind = TK_NUMBER;
          rescan = 1'b1;
        end
      end
      S_DOT: begin
        if (is_dig) begin
          cnt_nxt = cnt_inc;
          st_nxt  = S_FRAC;
        end else begin
          // The offending byte is part of the error token.
          a_emit = 1'b1;
          a_det  = char_byte;
          a_len  = 8'(cnt_inc);
          st_nxt = S_START;
        end
      end
      S_EXP, S_EXPSIGN: begin
        if (is_dig) begin
          cnt_nxt = cnt_inc;
          st_nxt  = S_EXPDIG;
        end else if (state_r == S_EXP && (char_byte == CH_PLUS || char_byte == CH_MINUS)) begin
          cnt_nxt = cnt_inc;
          st_nxt  = S_EXPSIGN;
        end else begin
          a_emit = 1'b1;
          a_det  = char_byte;
          rescan = 1'b1;
        end
      end
      S_EXPDIG: begin
        if (is_dig) begin
          cnt_nxt = cnt_inc;
        end else begin
          a_emit = 1'b1;
          a_kind = TK_NUMBER;
          rescan = 1'b1;
        end
      end
      S_LT: begin
        a_emit = 1'b1;
        a_kind = TK_RELOP;
        if (char_byte == CH_EQ) begin
          a_det  = RO_LE;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else if (char_byte == CH_GT) begin
          a_det  = RO_NE;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else begin
          a_det  = RO_LT;
          rescan = 1'b1;
        end
      end
      S_GT: begin
        a_emit = 1'b1;
        a_kind = TK_RELOP;
        if (char_byte == CH_EQ) begin
          a_det  = RO_GE;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else begin
          a_det  = RO_GT;
          rescan = 1'b1;
        end
      end
      S_EQ: begin
        a_emit = 1'b1;
        if (char_byte == CH_EQ) begin
          a_kind = TK_RELOP;
          a_det  = RO_EQ;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else begin
          a_kind = TK_ASSIGN;
          rescan = 1'b1;
        end
      end
      S_BAR: begin
        a_emit = 1'b1;
        if (char_byte == CH_BAR) begin
          a_kind = TK_BARBAR;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else begin
          a_kind = TK_BAR;
          rescan = 1'b1;
        end
      end
      S_AMP: begin
        a_emit = 1'b1;
        if (char_byte == CH_AMP) begin
          a_kind = TK_AMPAMP;
          a_len  = 8'd2;
          st_nxt = S_START;
        end else begin
          a_kind = TK_AMP;
          rescan = 1'b1;
        end
      end
      S_SLASH: begin
        if (char_byte == CH_STAR) begin
          st_nxt = S_BLOCK;
        end else if (char_byte == CH_SLASH) begin
          st_nxt = S_LINEC;
        end else begin
          a_emit = 1'b1;
          a_kind = TK_SLASH;
          rescan = 1'b1;
        end
      end
      S_BLOCK: begin
        if (char_byte == CH_STAR) begin
          st_nxt = S_STAR;
        end
      end
      S_STAR: begin
        if (char_byte == CH_SLASH) begin
          st_nxt = S_START;
        end else if (char_byte != CH_STAR) begin
          st_nxt = S_BLOCK;
        end
      end
      S_LINEC: begin
        if (char_byte == CH_NL) begin
          st_nxt = S_START;
        end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      st_nxt   = sb_state;
      cnt_nxt  = CW'(1);
      mask_nxt = sb_mask;
    end
  end

  // A start-state token counts only when the byte is actually decoded afresh.
  assign b_take   = rescan && b_emit;
  assign id_flush = close_ident(mask_nxt, cnt_nxt);

  // End-of-input flush of whatever token is still pending.
  always_comb begin
    f_emit = end_of_input;
    f_kind = TK_ERROR;
    f_det  = 8'd0;
    f_len  = 8'd1;
    case (st_nxt)
      S_IDENT: begin
        {f_kind, f_det} = id_flush;
        f_len = 8'(cnt_nxt);
      end
      S_INT, S_FRAC, S_EXPDIG: begin
        f_kind = TK_NUMBER;
        f_len  = 8'(cnt_nxt);
      end
      S_DOT, S_EXP, S_EXPSIGN: f_len = 8'(cnt_nxt);
      S_LT: f_kind = TK_RELOP;
      S_GT: begin
        f_kind = TK_RELOP;
        f_det  = RO_GT;
      end
      S_EQ:    f_kind = TK_ASSIGN;
      S_BAR:   f_kind = TK_BAR;
      S_AMP:   f_kind = TK_AMP;
      S_SLASH: f_kind = TK_SLASH;
      default: f_emit = 1'b0;
    endcase
  end

  always_comb begin
    res_a = '{kind: a_kind, detail: a_det, length: a_len, line: 16'(line_r), last: 1'b0};
    res_b = '{kind: b_kind, detail: char_byte, length: 8'd1, line: 16'(line_r),
              last: 1'b0};
    res_f = '{kind: f_kind, detail: f_det, length: f_len, line: 16'(line_r), last: 1'b0};
    push.n  = step ? 2'(a_emit) + 2'(b_take) + 2'(f_emit) : 2'd0;
    push.r0 = a_emit ? res_a : (b_take ? res_b : res_f);
    push.r1 = b_take ? res_b : res_f;
    push.r0.last = (push.n == 2'd1);
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      cnt_r   <= '0;
      mask_r  <= KW_ALL;
      line_r  <= LINE_BITS'(1);
    end else if (step) begin
      if (end_of_input) begin
        state_r <= S_START;
        cnt_r   <= '0;
        mask_r  <= KW_ALL;
        line_r  <= LINE_BITS'(1);
      end else begin
        state_r <= st_nxt;
        cnt_r   <= cnt_nxt;
        mask_r  <= mask_nxt;
        if (char_byte == CH_NL) begin
          line_r <= LINE_BITS'(line_r + 1'b1);
        end
      end
    end
  end

  // A byte that makes a token in the start state leaves nothing to flush.
  `LTS_ASSERT_NOW(a_no_third_result, clk, rst_n, step, !(b_take && f_emit))
  `LTS_ASSERT_NEXT(a_eoi_restart, clk, rst_n, step && end_of_input,
                   state_r == S_START && line_r == LINE_BITS'(1))

endmodule

>>> sv/lts_rq.sv
// ----------------------------------------------------------------------------
// lts_rq
// Four-entry result queue; takes up to two tokens per cycle and hands out
// one token per transaction.
// ----------------------------------------------------------------------------
`include "lexical_token_scanner_core_assert.svh"

module lts_rq import lts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lts_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output lts_res_t  out_res
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  lts_res_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // Room for the two results that a single byte may produce.
  assign room      = (cnt_r <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[AW'(wr_ptr_r + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= AW'(wr_ptr_r + push.n);
      if (pop) begin
        rd_ptr_r <= AW'(rd_ptr_r + 1'b1);
      end
      cnt_r <= (AW+1)'(cnt_r + push.n - pop);
    end
  end

  `LTS_ASSERT_NOW(a_push_fits, clk, rst_n, push.n != 2'd0,
                  cnt_r <= (AW+1)'(DEPTH - 2))
  `LTS_ASSERT_NEXT(a_count_holds, clk, rst_n, push.n == 2'd0 && !pop,
                   cnt_r == $past(cnt_r))

endmodule

>>> sv/lexical_token_scanner_core.sv
// ----------------------------------------------------------------------------
// lexical_token_scanner_core
// Byte-stream lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// The core takes one source byte per clock while the queue has room. Each
// accepted byte waits in an input register and is scanned in a cycle in which
// the queue has room; its tokens are written into a four-entry result queue
// at the end of that cycle and are offered at the output from the next one.
// A byte that closes a token and forms one itself, or a final byte whose
// flush adds a token, produces two tokens; the queue hands out one token per
// transaction, and a byte leaves the input register only while the queue has
// two free entries. With the output taking a token every cycle and one token
// per byte, the sustained rate is one byte per cycle.
module lexical_token_scanner_core import lts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lts_in_if.sink      in_if,
  lts_out_if.source   out_if
);

  logic       stg_vld_r;
  logic [7:0] stg_byte_r;
  logic       stg_eoi_r;
  logic       room, stg_fire;
  lts_push_t  push;
  lts_res_t   head;

  assign stg_fire    = stg_vld_r && room;
  assign in_if.ready = !stg_vld_r || stg_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      stg_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      stg_byte_r <= in_if.char_byte;
      stg_eoi_r  <= in_if.end_of_input;
    end
  end

  lts_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LINE_BITS     (LINE_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (stg_fire),
    .char_byte    (stg_byte_r),
    .end_of_input (stg_eoi_r),
    .push         (push)
  );

  lts_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (head)
  );

  assign out_if.token_kind   = head.kind;
  assign out_if.token_detail = head.detail;
  assign out_if.token_length = head.length;
  assign out_if.line_number  = head.line;
  assign out_if.last_of_run  = head.last;

endmodule
